### hdl/prox_card_26bit_frame_codec_assert.svh
// ----------------------------------------------------------------------------
// proximity card frame codec assertion macros
// concurrent checks on clk_i, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef PROX_CARD_26BIT_FRAME_CODEC_ASSERT_SVH
`define PROX_CARD_26BIT_FRAME_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

// check that holds out of reset
`define PCFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pcfc assertion failed");

// check that holds during reset as well
`define PCFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("pcfc assertion failed during reset");

`else

`define PCFC_ASSERT(lbl, prop)
`define PCFC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### hdl/pcfc_pkg.sv
// ----------------------------------------------------------------------------
// pcfc_pkg
// types and constants of the 26-bit proximity card frame codec
// ----------------------------------------------------------------------------
package pcfc_pkg;

  localparam int TDATA_W      = 128;
  localparam int FRAME_BITS   = 96;
  localparam int WIEGAND_BITS = 26;
  localparam int HALF_BITS    = 12;
  localparam int GROUPS       = 23;
  localparam int CHK_GROUPS   = 22;
  localparam int STREAM_BITS  = GROUPS * 3;
  localparam logic [7:0] LEN_CODE = 8'h1A;

  // reciprocals for exact division of narrow values by powers of ten
  localparam logic [16:0] RCP_10K = 17'd107375;  // shift 30, id < 2^16
  localparam logic [16:0] RCP_1K  = 17'd67109;   // shift 26
  localparam logic [16:0] RCP_100 = 17'd83887;   // shift 23
  localparam logic [16:0] RCP_10  = 17'd52429;   // shift 19
  localparam logic [7:0]  RCP_S100 = 8'd164;     // shift 14, site < 2^8
  localparam logic [7:0]  RCP_S10  = 8'd205;     // shift 11

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_DIGIT = 4'd1,
    ST_SITE_OVF  = 4'd2,
    ST_ID_OVF    = 4'd3,
    ST_LEAD      = 4'd4,
    ST_GRP_PAR   = 4'd5,
    ST_LENGTH    = 4'd6,
    ST_EVEN_PAR  = 4'd7,
    ST_ODD_PAR   = 4'd8
  } status_e;

  typedef struct packed {
    logic [63:0] frame_tail;
    logic [31:0] frame_head;
    logic [31:0] bcd_uid;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_frame_tail;
    logic [31:0] out_frame_head;
    logic [31:0] uid_digits;
  } out_word_t;

endpackage

### hdl/prox_card_26bit_frame_codec.sv
// ----------------------------------------------------------------------------
// prox_card_26bit_frame_codec
// converts 8-digit bcd card numbers to 96-bit nibble-parity frames and back
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   bcd_uid, frame_head, frame_tail         action
//  m_axis    out  uid_digits, out_frame_head, out_tail    status
//
//  one word per cycle sustained while m_axis does not stall; a word that is
//  taken passes through the input register, then the result register, to m_axis
//  the conversion is one pass of logic; its depth is set by the reciprocal
//  multipliers that split the 16-bit id into decimal digits
//  rst_ni clears both valid flags; payload registers are not reset
//  a stall on m_axis holds the result and fills the input register first
// ----------------------------------------------------------------------------
`include "prox_card_26bit_frame_codec_assert.svh"

module prox_card_26bit_frame_codec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [pcfc_pkg::TDATA_W-1:0]   s_axis_tdata_i,   // bcd_uid, frame_head, frame_tail
  input  logic [0:0]                     s_axis_tuser_i,   // action
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [pcfc_pkg::TDATA_W-1:0]   m_axis_tdata_o,   // uid_digits, out_frame_head, out_frame_tail
  output logic [3:0]                     m_axis_tuser_o    // status
);

  import pcfc_pkg::*;

  logic      in_vld_q, in_vld_d;
  logic      res_vld_q, res_vld_d;
  logic      res_adv;
  in_word_t  in_word_q;
  logic      in_act_q;
  out_word_t res_word_q, res_word_d;
  status_e   res_status_q, res_status_d;

  // ---------------------------------------------------------------- handshake
  assign res_adv         = !res_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || res_adv;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;
  assign res_vld_d       = res_adv ? in_vld_q : res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_word_q <= in_word_t'(s_axis_tdata_i);
      in_act_q  <= s_axis_tuser_i[0];
    end
    if (res_adv && in_vld_q) begin
      res_word_q   <= res_word_d;
      res_status_q <= res_status_d;
    end
  end

  // ---------------------------------------------------------------- encode
  logic [3:0]             dig [8];
  logic                   dig_bad;
  logic [10:0]            enc_site;
  logic [17:0]            enc_id;
  logic [23:0]            enc_data;
  logic [WIEGAND_BITS-1:0] enc_wg;
  logic [STREAM_BITS-1:0] enc_strm;   // bit j is stream bit j
  logic [FRAME_BITS-1:0]  enc_frm;    // frame bit k at position 95-k
  status_e                enc_status;

  always_comb begin
    dig_bad = 1'b0;
    for (int j = 0; j < 8; j++) begin
      dig[j]  = in_word_q.bcd_uid[31-4*j -: 4];
      dig_bad = dig_bad | (dig[j] > 4'd9);
    end
    enc_site = 11'(dig[0]) * 11'd100 + 11'(dig[1]) * 11'd10 + 11'(dig[2]);
    enc_id   = 18'(dig[3]) * 18'd10000 + 18'(dig[4]) * 18'd1000
             + 18'(dig[5]) * 18'd100 + 18'(dig[6]) * 18'd10 + 18'(dig[7]);

    if (dig_bad) begin
      enc_status = ST_BAD_DIGIT;
    end else if (enc_site > 11'd255) begin
      enc_status = ST_SITE_OVF;
    end else if (enc_id > 18'd65535) begin
      enc_status = ST_ID_OVF;
    end else begin
      enc_status = ST_OK;
    end

    enc_data = {enc_site[7:0], enc_id[15:0]};
    enc_wg   = {^enc_data[23:HALF_BITS], enc_data, ~^enc_data[HALF_BITS-1:0]};

    // three zero bits, length byte, wiegand word, then zeros
    enc_strm = '0;
    for (int i = 0; i < 8; i++) begin
      enc_strm[3+i] = LEN_CODE[7-i];
    end
    for (int i = 0; i < WIEGAND_BITS; i++) begin
      enc_strm[11+i] = enc_wg[WIEGAND_BITS-1-i];
    end

    // lead nibble stays zero, each group gets an odd parity bit
    enc_frm = '0;
    for (int g = 1; g <= GROUPS; g++) begin
      for (int i = 0; i < 3; i++) begin
        enc_frm[FRAME_BITS-1-(4*g+i)] = enc_strm[3*g-3+i];
      end
      enc_frm[FRAME_BITS-1-(4*g+3)] =
        ~(enc_strm[3*g-3] ^ enc_strm[3*g-2] ^ enc_strm[3*g-1]);
    end
  end

  // ---------------------------------------------------------------- decode
  logic [FRAME_BITS-1:0]  dec_frm;
  logic                   lead_bad;
  logic                   grp_bad;
  logic [STREAM_BITS-1:0] dec_strm;
  logic [7:0]             dec_len;
  logic [WIEGAND_BITS-1:0] dec_wg;
  logic [7:0]             dec_site;
  logic [15:0]            dec_id;
  logic [32:0]            p10k, p1k, p100, p10;
  logic [15:0]            ps100, ps10;
  logic [2:0]             q4;
  logic [6:0]             q3;
  logic [9:0]             q2;
  logic [12:0]            q1;
  logic [1:0]             sq2;
  logic [4:0]             sq1;
  logic [31:0]            dec_bcd;
  status_e                dec_status;

  always_comb begin
    dec_frm  = {in_word_q.frame_head, in_word_q.frame_tail};
    lead_bad = |dec_frm[FRAME_BITS-1 -: 4];
    grp_bad  = 1'b0;
    dec_strm = '0;
    for (int g = 1; g <= CHK_GROUPS; g++) begin
      grp_bad = grp_bad | (dec_frm[FRAME_BITS-1-(4*g+3)] !=
                ~(dec_frm[FRAME_BITS-1-4*g] ^ dec_frm[FRAME_BITS-1-(4*g+1)]
                  ^ dec_frm[FRAME_BITS-1-(4*g+2)]));
      for (int i = 0; i < 3; i++) begin
        dec_strm[3*g-3+i] = dec_frm[FRAME_BITS-1-(4*g+i)];
      end
    end
    for (int i = 0; i < 8; i++) begin
      dec_len[7-i] = dec_strm[3+i];
    end
    for (int i = 0; i < WIEGAND_BITS; i++) begin
      dec_wg[WIEGAND_BITS-1-i] = dec_strm[11+i];
    end

    if (lead_bad) begin
      dec_status = ST_LEAD;
    end else if (grp_bad) begin
      dec_status = ST_GRP_PAR;
    end else if (dec_len != 8'(WIEGAND_BITS)) begin
      dec_status = ST_LENGTH;
    end else if (dec_wg[25] != ^dec_wg[24:13]) begin
      dec_status = ST_EVEN_PAR;
    end else if (dec_wg[0] != ~^dec_wg[12:1]) begin
      dec_status = ST_ODD_PAR;
    end else begin
      dec_status = ST_OK;
    end

    dec_site = dec_wg[24:17];
    dec_id   = dec_wg[16:1];

    // floor(id / 10^k) in parallel, each digit is q_k - 10 * q_k+1
    p10k  = 33'(dec_id) * 33'(RCP_10K);
    p1k   = 33'(dec_id) * 33'(RCP_1K);
    p100  = 33'(dec_id) * 33'(RCP_100);
    p10   = 33'(dec_id) * 33'(RCP_10);
    q4    = p10k[30 +: 3];
    q3    = p1k[26 +: 7];
    q2    = p100[23 +: 10];
    q1    = p10[19 +: 13];
    ps100 = 16'(dec_site) * 16'(RCP_S100);
    ps10  = 16'(dec_site) * 16'(RCP_S10);
    sq2   = ps100[14 +: 2];
    sq1   = ps10[11 +: 5];

    dec_bcd[31:28] = 4'(sq2);
    dec_bcd[27:24] = 4'(sq1 - 5'(sq2) * 5'd10);
    dec_bcd[23:20] = 4'(dec_site - 8'(sq1) * 8'd10);
    dec_bcd[19:16] = 4'(q4);
    dec_bcd[15:12] = 4'(q3 - 7'(q4) * 7'd10);
    dec_bcd[11:8]  = 4'(q2 - 10'(q3) * 10'd10);
    dec_bcd[7:4]   = 4'(q1 - 13'(q2) * 13'd10);
    dec_bcd[3:0]   = 4'(dec_id - 16'(q1) * 16'd10);
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    res_word_d = '0;
    if (in_act_q == ACT_DECODE) begin
      res_status_d = dec_status;
      if (dec_status == ST_OK) begin
        res_word_d.uid_digits = dec_bcd;
      end
    end else begin
      res_status_d = enc_status;
      if (enc_status == ST_OK) begin
        res_word_d.out_frame_head = enc_frm[FRAME_BITS-1 -: 32];
        res_word_d.out_frame_tail = enc_frm[63:0];
      end
    end
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = res_word_q;
  assign m_axis_tuser_o  = res_status_q;

  // ---------------------------------------------------------------- checks
  `PCFC_ASSERT(a_err_zero, m_axis_tvalid_o && m_axis_tuser_o != ST_OK |-> m_axis_tdata_o == '0)
  `PCFC_ASSERT(a_one_side, m_axis_tvalid_o && |m_axis_tdata_o[31:0] |-> ~|m_axis_tdata_o[127:32])
  `PCFC_ASSERT(a_take_fill, s_axis_tvalid_i && s_axis_tready_o |=> in_vld_q)
  `PCFC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid_o && !in_vld_q)

endmodule
